/* src/vzd_pkg.sv */
// Shared types and constants for the varint zigzag decoder.
`default_nettype none

package vzd_pkg;

    // Default for the longest varint accepted.
    localparam int MAX_BYTES_DEFAULT = 10;

    // Fixed field widths.
    localparam int BYTE_W       = 8;
    localparam int VALUE_W      = 64;
    localparam int BYTE_COUNT_W = 4;
    localparam int MODE_W       = 2;
    localparam int SHIFT_W      = 6;

    // Each byte carries seven payload bits under a continuation flag.
    localparam int PAYLOAD_W    = 7;
    localparam int CONT_BIT     = 7;

    // Zigzag mode register codes.
    typedef enum logic [MODE_W-1:0] {
        MODE_PLAIN    = 2'd0,
        MODE_ZIGZAG32 = 2'd1,
        MODE_ZIGZAG64 = 2'd2
    } zigzag_mode_t;

endpackage : vzd_pkg

`default_nettype wire

/* src/vzd_unzig.sv */
// Zigzag decode of a completed varint value, selected by the mode register.
`default_nettype none

module vzd_unzig
    import vzd_pkg::*;
(
    input  wire logic [MODE_W-1:0]  mode,
    input  wire logic [VALUE_W-1:0] value_in,
    output logic      [VALUE_W-1:0] value_out
);

    logic [31:0] word_lo;
    logic [31:0] dec32;
    logic [VALUE_W-1:0] dec64;

    // Both decodes are built in parallel; the mode picks one.
    always_comb begin
        word_lo = value_in[31:0];
        dec32   = {1'b0, word_lo[31:1]} ^ {32{word_lo[0]}};
        dec64   = {1'b0, value_in[VALUE_W-1:1]} ^ {VALUE_W{value_in[0]}};
    end

    // Unused mode code falls back to plain unsigned.
    always_comb begin
        unique case (mode)
            MODE_ZIGZAG32: value_out = {{(VALUE_W-32){dec32[31]}}, dec32};
            MODE_ZIGZAG64: value_out = dec64;
            default:       value_out = value_in;
        endcase
    end

endmodule : vzd_unzig

`default_nettype wire

/* src/varint_zigzag_decoder_core.sv */
// Top level of the base-128 varint decoder with optional zigzag decoding.
//
// The core takes one encoded byte per transaction and accepts a new byte in
// every clock cycle unless a held result waits for m_ready. Each byte's seven
// payload bits are merged into a 64-bit accumulator in the same cycle it is
// accepted; a byte with bit 7 clear closes the varint, and its decoded value,
// byte count and an overlong flag of zero are loaded into the result register,
// which drives the m_ port. MAX_BYTES continuing bytes in a row give a result
// with value zero, byte count MAX_BYTES and the overlong flag set, after which a
// new varint starts. Payload bits above bit 63 are dropped. The zigzag mode
// register (0 plain, 1 32-bit zigzag sign-extended, 2 64-bit zigzag, 3 acts as
// plain) is sampled when a varint completes and should only be written while the
// core is idle. The single result register frees the input side whenever it is
// empty or being drained, so throughput is one byte per cycle with no stall
// unless m_ready is held low.
`default_nettype none

module varint_zigzag_decoder_core
    import vzd_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,

    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [MODE_W-1:0]       cfg_zigzag_mode,

    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [BYTE_W-1:0]       s_byte_in,

    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [VALUE_W-1:0]           m_value,
    output logic [BYTE_COUNT_W-1:0]      m_byte_count,
    output logic                         m_overlong
);

    localparam int CNT_W = $clog2(MAX_BYTES + 1);

    logic [MODE_W-1:0]        mode_reg;
    logic [VALUE_W-1:0]       acc_reg, acc_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_plus;
    logic [SHIFT_W-1:0]       shamt;
    logic [VALUE_W-1:0]       payload_ext;
    logic [VALUE_W-1:0]       unzig_value;
    logic                     in_xfer;
    logic                     cont;
    logic                     ends_normal;
    logic                     ends_overlong;

    logic                     m_valid_reg;
    logic [VALUE_W-1:0]       m_value_reg;
    logic [BYTE_COUNT_W-1:0]  m_byte_count_reg;
    logic                     m_overlong_reg;

    // The register port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
        end else if (cfg_valid) begin
            mode_reg <= cfg_zigzag_mode;
        end
    end

    // Input is free whenever the result register is empty or being drained.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    // Merge the new payload group at bit 7 * (byte index).
    always_comb begin
        shamt         = SHIFT_W'(cnt_reg) * SHIFT_W'(PAYLOAD_W);
        payload_ext   = {{(VALUE_W-PAYLOAD_W){1'b0}}, s_byte_in[PAYLOAD_W-1:0]};
        acc_next      = acc_reg | (payload_ext << shamt);
        cnt_plus      = cnt_reg + CNT_W'(1);
        cont          = s_byte_in[CONT_BIT];
        ends_normal   = !cont;
        ends_overlong = cont && (cnt_plus == CNT_W'(MAX_BYTES));
    end

    vzd_unzig u_unzig (
        .mode      (mode_reg),
        .value_in  (acc_next),
        .value_out (unzig_value)
    );

    // Accumulator and byte counter; both clear when a varint closes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end else if (in_xfer) begin
            if (ends_normal || ends_overlong) begin
                acc_reg <= '0;
                cnt_reg <= '0;
            end else begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_plus;
            end
        end
    end

    // Result register: valid is control, the payload loads without reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer && (ends_normal || ends_overlong)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && (ends_normal || ends_overlong)) begin
            m_value_reg      <= ends_overlong ? '0 : unzig_value;
            m_byte_count_reg <= BYTE_COUNT_W'(cnt_plus);
            m_overlong_reg   <= ends_overlong;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_byte_count = m_byte_count_reg;
    assign m_overlong   = m_overlong_reg;

endmodule : varint_zigzag_decoder_core

`default_nettype wire

/* src/vzd_checker.sv */
// Port-level checker for the varint decoder core, with its bind statement.
`default_nettype none

module vzd_checker
    import vzd_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEFAULT
) (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_valid,
    input wire logic                    s_ready,
    input wire logic [BYTE_W-1:0]       s_byte_in,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic [VALUE_W-1:0]      m_value,
    input wire logic [BYTE_COUNT_W-1:0] m_byte_count,
    input wire logic                    m_overlong
);

    // An overlong transaction always reports a zero value.
    a_overlong_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overlong) |-> (m_value == '0))
        else $error("overlong result with nonzero value");

    // An overlong transaction always reports the full byte count.
    a_overlong_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overlong) |-> (m_byte_count == BYTE_COUNT_W'(MAX_BYTES)))
        else $error("overlong result with wrong byte count");

    // Every result carries a byte count between one and MAX_BYTES.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_byte_count != '0) &&
                     (m_byte_count <= BYTE_COUNT_W'(MAX_BYTES))))
        else $error("byte count out of range");

    // A closing byte yields a result in the next cycle.
    a_close_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_byte_in[CONT_BIT]) |=> m_valid)
        else $error("closing byte produced no result");

    // A stalled result holds its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_value) && $stable(m_byte_count) &&
             $stable(m_overlong)))
        else $error("stalled result changed");

endmodule : vzd_checker

bind varint_zigzag_decoder_core vzd_checker #(.MAX_BYTES(MAX_BYTES)) u_vzd_checker (.*);

`default_nettype wire

/* tb/sv/tb_varint_zigzag_decoder_core.sv */
// Self-checking testbench for the varint zigzag decoder core.
module tb_varint_zigzag_decoder_core;
    import vzd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES   = MAX_BYTES_DEFAULT;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PHASE_BYTES = 108;
    localparam int NUM_PHASES  = 6;
    localparam int QUIET_PHASE = 2;

    // The fourth mode code has no name in the package and decodes as plain.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // One decoded varint as it leaves the core.
    typedef struct packed {
        logic [VALUE_W-1:0]      value;
        logic [BYTE_COUNT_W-1:0] byte_count;
        logic                    overlong;
    } varint_result_t;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [BYTE_W-1:0]       data;
        logic                    typed;
        logic [VALUE_W-1:0]      value;
        logic [BYTE_COUNT_W-1:0] byte_count;
        logic                    overlong;
    } stim_row_t;

    localparam int NUM_ROWS = 25;

    // Short values, a ten-byte value whose payload bits above bit 63 are dropped,
    // an overlong run, one varint under each zigzag mode and one under the unused code.
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{MODE_PLAIN,    8'h00, 1'b1, 64'h0000_0000_0000_0000, 4'd1,  1'b0},
        '{MODE_PLAIN,    8'h7f, 1'b1, 64'h0000_0000_0000_007f, 4'd1,  1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'h7e, 1'b1, 64'h7fff_ffff_ffff_ffff, 4'd10, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b0, 64'h0, 4'd0, 1'b0},
        '{MODE_PLAIN,    8'hff, 1'b1, 64'h0000_0000_0000_0000, 4'd10, 1'b1},
        '{MODE_ZIGZAG32, 8'h01, 1'b1, 64'hffff_ffff_ffff_ffff, 4'd1,  1'b0},
        '{MODE_ZIGZAG64, 8'h03, 1'b1, 64'hffff_ffff_ffff_fffe, 4'd1,  1'b0},
        '{MODE_UNUSED,   8'h01, 1'b1, 64'h0000_0000_0000_0001, 4'd1,  1'b0}
    };

    localparam logic [MODE_W-1:0] PHASE_MODES [NUM_PHASES] = '{
        MODE_ZIGZAG64, MODE_ZIGZAG32, MODE_PLAIN, MODE_UNUSED, MODE_ZIGZAG32, MODE_ZIGZAG64
    };

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [MODE_W-1:0]       cfg_zigzag_mode = MODE_PLAIN;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [BYTE_W-1:0]       s_byte_in = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [VALUE_W-1:0]      m_value;
    logic [BYTE_COUNT_W-1:0] m_byte_count;
    logic                    m_overlong;

    // Decoder state mirrored by the predictor.
    logic [VALUE_W-1:0]      acc_bits = '0;
    logic [BYTE_COUNT_W-1:0] acc_bytes = '0;
    logic [MODE_W-1:0]       mode_now = MODE_PLAIN;

    varint_result_t pending_results [$];

    // No idling on either side while this is set.
    bit quiet = 1'b0;

    int error_count    = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int overlong_seen  = 0;
    int mode_writes    = 0;
    int cycle_count    = 0;

    varint_zigzag_decoder_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_zigzag_mode (cfg_zigzag_mode),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .m_byte_count    (m_byte_count),
        .m_overlong      (m_overlong)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Run limit in case the core hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("tb_varint_zigzag_decoder_core NOT OK");
            $finish;
        end
    end

    // Merges one byte into the mirrored accumulator and returns 1 when it
    // closes a varint, either normally or as an overlong run.
    function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output varint_result_t r);
        logic [VALUE_W-1:0]      v;
        logic [31:0]             w;
        logic [31:0]             d;
        logic [BYTE_COUNT_W-1:0] n;
        r = '0;
        acc_bits = acc_bits | (VALUE_W'(b[PAYLOAD_W-1:0]) << (PAYLOAD_W * acc_bytes));
        n = acc_bytes + 1'b1;
        if (b[CONT_BIT]) begin
            if (n < MAX_BYTES) begin
                acc_bytes = n;
                return 1'b0;
            end
            r.byte_count = BYTE_COUNT_W'(MAX_BYTES);
            r.overlong   = 1'b1;
        end else begin
            case (mode_now)
                MODE_ZIGZAG32: begin
                    w = acc_bits[31:0];
                    d = (w >> 1) ^ {32{w[0]}};
                    v = {{32{d[31]}}, d};
                end
                MODE_ZIGZAG64: begin
                    v = (acc_bits >> 1) ^ {VALUE_W{acc_bits[0]}};
                end
                default: begin
                    v = acc_bits;
                end
            endcase
            r.value      = v;
            r.byte_count = n;
        end
        acc_bits  = '0;
        acc_bytes = '0;
        return 1'b1;
    endfunction

    // Presents one byte, with an occasional gap first, and waits for its
    // transaction; the prediction is made at the accepting edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b, output bit closes,
                             output varint_result_t r);
        while (!quiet && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        closes = decode_byte(b, r);
    endtask

    // Holds the sender until every expected result has come, plus the
    // core's short pipeline.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes the zigzag mode register while the core is idle.
    task automatic write_mode(input logic [MODE_W-1:0] m);
        wait_idle();
        cfg_valid       <= 1'b1;
        cfg_zigzag_mode <= m;
        do @(posedge aclk); while (!cfg_ready);
        mode_now = m;
        mode_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Sends one random varint: mostly well formed with lengths up to the
    // maximum, sometimes an overlong run of continuing bytes.
    task automatic send_varint();
        int             kind;
        int             len;
        int             fill;
        logic [6:0]     payload;
        bit             closes;
        varint_result_t r;
        kind = $urandom_range(99);
        if (kind < 8) begin
            len = MAX_BYTES;
        end else if (kind < 40) begin
            len = $urandom_range(2, 1);
        end else if (kind < 70) begin
            len = $urandom_range(5, 3);
        end else begin
            len = $urandom_range(MAX_BYTES, 6);
        end
        for (int i = 0; i < len; i++) begin
            fill = $urandom_range(99);
            if (fill < 10) begin
                payload = 7'h7f;
            end else if (fill < 18) begin
                payload = 7'h00;
            end else begin
                payload = 7'($urandom);
            end
            // An overlong run keeps the continuation flag on every byte.
            send_byte({(kind < 8) || (i < len - 1), payload}, closes, r);
            if (closes) begin
                pending_results.push_back(r);
            end
        end
    endtask

    // Result side: random backpressure and comparison with the oldest expectation.
    always @(posedge aclk) begin
        varint_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: value %h, byte_count %0d, overlong %0b",
                       m_value, m_byte_count, m_overlong);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_seen++;
                if (m_overlong === 1'b1 && want.overlong) begin
                    overlong_seen++;
                end
                if (m_value !== want.value) begin
                    $error("value: expected %h, actual %h", want.value, m_value);
                    error_count++;
                end
                if (m_byte_count !== want.byte_count) begin
                    $error("byte_count: expected %0d, actual %0d", want.byte_count, m_byte_count);
                    error_count++;
                end
                if (m_overlong !== want.overlong) begin
                    $error("overlong: expected %0b, actual %0b", want.overlong, m_overlong);
                    error_count++;
                end
            end
        end
        m_ready <= quiet || ($urandom_range(99) >= 6);
    end

    // Stimulus: reset, the directed table, then random phases under each mode.
    initial begin
        bit             closes;
        varint_result_t r;
        stim_row_t      row;
        int             phase_start;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; a mode change between rows waits for the core to drain.
        for (int i = 0; i < NUM_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.mode != mode_now) begin
                write_mode(row.mode);
            end
            send_byte(row.data, closes, r);
            if (closes) begin
                if (row.typed) begin
                    pending_results.push_back('{row.value, row.byte_count, row.overlong});
                end else begin
                    pending_results.push_back(r);
                end
            end
        end

        // Random phases, each closing on a varint boundary before the mode changes.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_mode(PHASE_MODES[p]);
            quiet = (p == QUIET_PHASE);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                send_varint();
                if ($urandom_range(39) == 0) begin
                    wait_idle();
                end
            end
            quiet = 1'b0;
        end

        wait_idle();
        repeat (20) @(posedge aclk);

        $display("Sent %0d bytes over %0d mode writes; checked %0d results, %0d of them overlong.",
                 bytes_sent, mode_writes, results_seen, overlong_seen);
        $display("Modes covered: plain, 32-bit and 64-bit zigzag, and the unused code.");
        if (error_count == 0) begin
            $display("tb_varint_zigzag_decoder_core OK");
        end else begin
            $display("tb_varint_zigzag_decoder_core NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/vzd_pkg.sv
src/vzd_unzig.sv
src/varint_zigzag_decoder_core.sv
src/vzd_checker.sv
tb/sv/tb_varint_zigzag_decoder_core.sv
